>>> src/table_waveform_generator_with_agc_assert.svh
// Assertion macros for the table waveform generator
`ifndef TABLE_WAVEFORM_GENERATOR_WITH_AGC_ASSERT_SVH
`define TABLE_WAVEFORM_GENERATOR_WITH_AGC_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clock, off during reset
`define TWG_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);
// Next-cycle implication
`define TWG_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define TWG_ASSERT_NOW(lbl, pre, post, msg)
`define TWG_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> src/twg_pkg.sv
// Types, constants and waveform tables for the table waveform generator
`default_nettype none

package twg_pkg;

   localparam int WAVE_LEN   = 20;
   localparam int ADC_BITS   = 10;
   localparam int TABLE_SIZE = 20;
   localparam int PHASE_W    = $clog2(WAVE_LEN);
   localparam int TBL_IDX_W  = $clog2(TABLE_SIZE);

   localparam int OP_W       = 2;
   localparam int SEL_W      = 2;
   localparam int AMP_W      = 8;
   localparam int ENTRY_W    = 7;
   localparam int GAIN_W     = 4;
   localparam int WAVE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = ADC_BITS;

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
   localparam logic [OP_W-1:0] OP_GAIN_UP   = 2'd1;
   localparam logic [OP_W-1:0] OP_GAIN_DOWN = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SELECT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AGC_ENABLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_THRESH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_THRESH  = 3'd4;

   // waveform selections
   localparam logic [SEL_W-1:0] SEL_SINE     = 2'd0;
   localparam logic [SEL_W-1:0] SEL_TRIANGLE = 2'd1;
   localparam logic [SEL_W-1:0] SEL_SAWTOOTH = 2'd2;
   localparam logic [SEL_W-1:0] SEL_SQUARE   = 2'd3;

   // reset values
   localparam logic [AMP_W-1:0]    AMP_RESET  = 8'd255;
   localparam logic [ADC_BITS-1:0] HIGH_RESET = ADC_BITS'(614);
   localparam logic [ADC_BITS-1:0] LOW_RESET  = ADC_BITS'(164);
   localparam logic [GAIN_W-1:0]   GAIN_RESET = 4'd10;
   localparam logic [GAIN_W-1:0]   GAIN_MIN   = 4'd1;
   localparam logic [GAIN_W-1:0]   GAIN_MAX   = 4'd15;

   // shared multiplier and reciprocal constants
   // x/100 = (x*5243)>>19 exact for x < 43690; x/15 = (x*4370)>>16 exact for x < 4681
   localparam int MUL_A_W  = 15;
   localparam int MUL_B_W  = 13;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam logic [MUL_B_W-1:0] RECIP100 = 13'd5243;
   localparam int SHIFT100 = 19;
   localparam logic [MUL_B_W-1:0] RECIP15  = 13'd4370;
   localparam int SHIFT15  = 16;

   typedef logic [ENTRY_W-1:0] entry_type;

   localparam entry_type SINE_TBL [TABLE_SIZE] = '{
      7'd0, 7'd16, 7'd31, 7'd46, 7'd59, 7'd71, 7'd81, 7'd90, 7'd96, 7'd99,
      7'd100, 7'd99, 7'd96, 7'd90, 7'd81, 7'd71, 7'd59, 7'd46, 7'd31, 7'd16};
   localparam entry_type TRI_TBL [TABLE_SIZE] = '{
      7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90,
      7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10};
   localparam entry_type SAW_TBL [TABLE_SIZE] = '{
      7'd0, 7'd5, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45,
      7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95};
   localparam entry_type SQR_TBL [TABLE_SIZE] = '{
      7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
      7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0};

   // Table read; a phase past the stored entries reads zero
   function automatic entry_type wave_entry(input logic [SEL_W-1:0] sel,
                                            input logic [PHASE_W-1:0] ph);
      logic [TBL_IDX_W-1:0] idx;
      entry_type            val;
      idx = TBL_IDX_W'(ph);
      unique case (sel)
         SEL_SINE:     val = SINE_TBL[idx];
         SEL_TRIANGLE: val = TRI_TBL[idx];
         SEL_SAWTOOTH: val = SAW_TBL[idx];
         SEL_SQUARE:   val = SQR_TBL[idx];
         default:      val = '0;
      endcase
      if (int'(ph) >= TABLE_SIZE) begin
         val = '0;
      end
      return val;
   endfunction

endpackage

`default_nettype wire

>>> src/twg_if.sv
// Channel interfaces: request, response and register write
`default_nettype none

interface twg_req_if import twg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [ADC_BITS-1:0] adc_sample;
   modport source (output valid, operation, adc_sample, input ready);
   modport sink   (input valid, operation, adc_sample, output ready);
endinterface

interface twg_rsp_if import twg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WAVE_W-1:0] wave_out;
   logic [GAIN_W-1:0] gain_level;
   modport source (output valid, wave_out, gain_level, input ready);
   modport sink   (input valid, wave_out, gain_level, output ready);
endinterface

interface twg_csr_if import twg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/table_waveform_generator_with_agc.sv
// Top level: table waveform generator with automatic gain control
//
// Channels: req_chan takes one beat per item (operation, adc_sample); rsp_chan
// returns exactly one beat per item (wave_out, gain_level); csr_chan writes the
// five registers (index 0 wave_select .. 4 low_threshold) and is always ready.
// A tick adjusts the gain from adc_sample when auto gain is on, reads the
// waveform table at the current phase, scales by amplitude and gain and steps
// the phase. Gain up/down beats wrap the gain in 1..15 and return the held value.
// Sequence: one 15x13 multiplier is shared over four passes (amplitude*entry,
// /100 by reciprocal, *gain, /15 by reciprocal); a tick then takes the quotient
// into held and loads the response register, and a gain beat goes straight to
// the response step. req ready is high only while the sequencer is idle, so a
// new item is taken only after the last one is done; one item is in work at a time.
// The response sits in an output register, so the next item is accepted while
// a result waits; if the receiver stalls, the following result waits in the
// final step until the output register frees, and req stays low meanwhile.
// Reset (synchronous, active high): registers to their defaults (sine,
// amplitude 255, auto gain off, thresholds 614/164), phase 0, gain 10,
// held output 0, no response pending. No clearing pass is needed.
`default_nettype none

module table_waveform_generator_with_agc import twg_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   twg_req_if.sink    req_chan,
   twg_rsp_if.source  rsp_chan,
   twg_csr_if.sink    csr_chan
);

`include "table_waveform_generator_with_agc_assert.svh"

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_MUL_AMP  = 3'd1;  // amplitude * entry
   localparam logic [2:0] ST_DIV100   = 3'd2;  // * reciprocal of 100
   localparam logic [2:0] ST_MUL_GAIN = 3'd3;  // quotient * gain
   localparam logic [2:0] ST_DIV15    = 3'd4;  // * reciprocal of 15
   localparam logic [2:0] ST_SCALE    = 3'd5;  // take the quotient into held
   localparam logic [2:0] ST_DONE     = 3'd6;  // load response register

   logic [2:0]          state_ff, state_in;
   logic [SEL_W-1:0]    sel_ff, sel_in;
   logic [AMP_W-1:0]    amp_ff, amp_in;
   logic                agc_ff, agc_in;
   logic [ADC_BITS-1:0] high_ff, high_in;
   logic [ADC_BITS-1:0] low_ff, low_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [WAVE_W-1:0]   held_ff, held_in;
   entry_type           entry_ff, entry_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WAVE_W-1:0]   rsp_wave_ff, rsp_wave_in;
   logic [GAIN_W-1:0]   rsp_gain_ff, rsp_gain_in;

   logic                req_fire;
   logic                slot_free;
   logic [GAIN_W-1:0]   gain_dn, gain_agc;
   logic [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]  mul_b;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.wave_out   = rsp_wave_ff;
   assign rsp_chan.gain_level = rsp_gain_ff;

   // output register can take a beat this cycle
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // AGC: decrement above high threshold, then separately increment below low
   always_comb begin
      gain_dn  = ((req_chan.adc_sample > high_ff) && (gain_ff > GAIN_MIN)) ?
                 gain_ff - GAIN_W'(1) : gain_ff;
      gain_agc = ((req_chan.adc_sample < low_ff) && (gain_dn < GAIN_MAX)) ?
                 gain_dn + GAIN_W'(1) : gain_dn;
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_AMP: begin
            mul_a = MUL_A_W'(amp_ff);
            mul_b = MUL_B_W'(entry_ff);
         end
         ST_DIV100: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = RECIP100;
         end
         ST_MUL_GAIN: begin
            mul_a = MUL_A_W'(prod_ff[PROD_W-1:SHIFT100]);
            mul_b = MUL_B_W'(gain_ff);
         end
         ST_DIV15: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = RECIP15;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      amp_in       = amp_ff;
      agc_in       = agc_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      phase_in     = phase_ff;
      gain_in      = gain_ff;
      held_in      = held_ff;
      entry_in     = entry_ff;
      prod_in      = PROD_W'(mul_a) * PROD_W'(mul_b);
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_wave_in  = rsp_wave_ff;
      rsp_gain_in  = rsp_gain_ff;

      // register writes
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_WAVE_SELECT: sel_in  = csr_chan.data[SEL_W-1:0];
            CSR_AMPLITUDE:   amp_in  = csr_chan.data[AMP_W-1:0];
            CSR_AGC_ENABLE:  agc_in  = csr_chan.data[0];
            CSR_HIGH_THRESH: high_in = csr_chan.data[ADC_BITS-1:0];
            CSR_LOW_THRESH:  low_in  = csr_chan.data[ADC_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_chan.operation)
                  OP_TICK: begin
                     if (agc_ff) begin
                        gain_in = gain_agc;
                     end
                     entry_in = wave_entry(sel_ff, phase_ff);
                     phase_in = (phase_ff == PHASE_W'(WAVE_LEN - 1)) ?
                                '0 : phase_ff + PHASE_W'(1);
                     state_in = ST_MUL_AMP;
                  end
                  OP_GAIN_UP: begin
                     gain_in  = (gain_ff >= GAIN_MAX) ? GAIN_MIN : gain_ff + GAIN_W'(1);
                     state_in = ST_DONE;
                  end
                  OP_GAIN_DOWN: begin
                     gain_in  = (gain_ff <= GAIN_MIN) ? GAIN_MAX : gain_ff - GAIN_W'(1);
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;  // unused code: report only
               endcase
            end
         end
         ST_MUL_AMP:  state_in = ST_DIV100;
         ST_DIV100:   state_in = ST_MUL_GAIN;
         ST_MUL_GAIN: state_in = ST_DIV15;
         ST_DIV15:    state_in = ST_SCALE;
         ST_SCALE: begin
            held_in  = prod_ff[SHIFT15+WAVE_W-1:SHIFT15];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_wave_in  = held_ff;
               rsp_gain_in  = gain_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_SINE;
         amp_ff       <= AMP_RESET;
         agc_ff       <= 1'b0;
         high_ff      <= HIGH_RESET;
         low_ff       <= LOW_RESET;
         phase_ff     <= '0;
         gain_ff      <= GAIN_RESET;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         amp_ff       <= amp_in;
         agc_ff       <= agc_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         phase_ff     <= phase_in;
         gain_ff      <= gain_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      prod_ff     <= prod_in;
      rsp_wave_ff <= rsp_wave_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   `TWG_ASSERT_NOW(a_gain_range, 1'b1, gain_ff != '0, "gain left the range 1..15")
   `TWG_ASSERT_NOW(a_phase_range, 1'b1, int'(phase_ff) < WAVE_LEN, "phase past table length")
   `TWG_ASSERT_NEXT(a_held_only_scale, state_ff != ST_SCALE, $stable(held_ff),
                    "held output changed outside the scale step")
   `TWG_ASSERT_NEXT(a_gain_busy, state_ff != ST_IDLE, $stable(gain_ff),
                    "gain changed while an item is in work")
   `TWG_ASSERT_NEXT(a_tick_start, req_fire && req_chan.operation == OP_TICK,
                    state_ff == ST_MUL_AMP, "tick did not start the multiply sequence")

endmodule

`default_nettype wire
